// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the constant-pool parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CCPP_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CCPP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ccpp_pkg.sv -----
// Shared types, constants and decode functions of the constant-pool parser.
package ccpp_pkg;

    localparam int unsigned POOL_SLOTS_DEFAULT = 4096;
    localparam int unsigned STORE_W = 37;

    localparam logic [7:0] T_UTF8    = 8'd1;
    localparam logic [7:0] T_INT     = 8'd3;
    localparam logic [7:0] T_FLOAT   = 8'd4;
    localparam logic [7:0] T_LONG    = 8'd5;
    localparam logic [7:0] T_DOUBLE  = 8'd6;
    localparam logic [7:0] T_CLASS   = 8'd7;
    localparam logic [7:0] T_STRING  = 8'd8;
    localparam logic [7:0] T_FREF    = 8'd9;
    localparam logic [7:0] T_MREF    = 8'd10;
    localparam logic [7:0] T_IMREF   = 8'd11;
    localparam logic [7:0] T_NAT     = 8'd12;
    localparam logic [7:0] T_MHANDLE = 8'd15;
    localparam logic [7:0] T_MTYPE   = 8'd16;
    localparam logic [7:0] T_INDY    = 8'd18;

    localparam logic [15:0] KIND_MIN = 16'd1;
    localparam logic [15:0] KIND_MAX = 16'd9;

    localparam logic [1:0] RK_ENTRY   = 2'd0;
    localparam logic [1:0] RK_PAYLOAD = 2'd1;
    localparam logic [1:0] RK_VERDICT = 2'd2;
    localparam logic [1:0] RK_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_ZERO  = 3'd1;
    localparam logic [2:0] ERR_TAG   = 3'd2;
    localparam logic [2:0] ERR_KIND  = 3'd3;
    localparam logic [2:0] ERR_REF   = 3'd4;
    localparam logic [2:0] ERR_CAP   = 3'd5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_COUNT,
        OP_TAG,
        OP_FIELD,
        OP_PAY,
        OP_PAD,
        OP_W_ISS,
        OP_W_ENT,
        OP_W_ARD,
        OP_W_BRD
    } dp_op_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_ENTRY,
        EM_PAYLOAD,
        EM_CNT_ERR,
        EM_TAG_ERR,
        EM_WALK_ERR,
        EM_VERDICT
    } emit_t;

    typedef struct packed {
        dp_op_t     op;
        logic       adv;
        logic       walk_inc;
        emit_t      emit;
        logic [2:0] err;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic cnt_over;
        logic cnt_one;
        logic tag_ok;
        logic fld_last;
        logic utf8_more;
        logic pay_last;
        logic adv_end;
        logic pad_need;
        logic walk_end;
        logic kind_bad;
        logic need_a;
        logic need_b;
        logic a_bad_idx;
        logic b_bad_idx;
        logic a_ok;
        logic b_ok;
    } status_t;

    // Number of field bytes that follow a tag; zero marks an unknown tag.
    function automatic logic [3:0] field_bytes(input logic [7:0] tag);
        logic [3:0] n;
        unique case (tag)
            T_UTF8, T_CLASS, T_STRING, T_MTYPE: n = 4'd2;
            T_INT, T_FLOAT:                     n = 4'd4;
            T_FREF, T_MREF, T_IMREF, T_NAT,
            T_INDY:                             n = 4'd4;
            T_LONG, T_DOUBLE:                   n = 4'd8;
            T_MHANDLE:                          n = 4'd3;
            default:                            n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic needs_a(input logic [7:0] tag);
        logic r;
        unique case (tag)
            T_CLASS, T_STRING, T_MTYPE, T_FREF, T_MREF, T_IMREF,
            T_NAT, T_MHANDLE: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic needs_b(input logic [7:0] tag);
        logic r;
        unique case (tag)
            T_FREF, T_MREF, T_IMREF, T_NAT, T_INDY: r = 1'b1;
            default:                                r = 1'b0;
        endcase
        return r;
    endfunction

    // Does the tag found at the first reference satisfy the referring entry?
    function automatic logic ref_a_ok(input logic [7:0] tag, input logic [7:0] got);
        logic r;
        unique case (tag)
            T_CLASS, T_STRING, T_MTYPE, T_NAT: r = (got == T_UTF8);
            T_FREF, T_MREF, T_IMREF:           r = (got == T_CLASS);
            T_MHANDLE: r = (got == T_FREF) || (got == T_MREF) || (got == T_IMREF);
            default:                           r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic ref_b_ok(input logic [7:0] tag, input logic [7:0] got);
        logic r;
        unique case (tag)
            T_FREF, T_MREF, T_IMREF, T_INDY: r = (got == T_NAT);
            T_NAT:                           r = (got == T_UTF8);
            default:                         r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/ccpp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ccpp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/ccpp_dp.sv -----
// Datapath of the constant-pool parser: field assembly, slot store, walk, result register.
`include "assert_macros.svh"

module ccpp_dp #(
    parameter int unsigned POOL_SLOTS = ccpp_pkg::POOL_SLOTS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ccpp_pkg::cmd_t   cmd,
    output ccpp_pkg::status_t st,
    input  logic [7:0]       data_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       result_kind,
    output logic [15:0]      slot,
    output logic [7:0]       entry_tag,
    output logic [15:0]      first_index,
    output logic [15:0]      second_index,
    output logic [7:0]       reference_kind,
    output logic [63:0]      constant_bits,
    output logic [7:0]       payload_byte,
    output logic [2:0]       error_code,
    output logic             last
);

    localparam int unsigned AW = $clog2(POOL_SLOTS);
    localparam logic [16:0] CAP_LIMIT = 17'(POOL_SLOTS + 1);

    logic [63:0] acc_reg, acc_next;
    logic [7:0]  cur_tag_reg, cur_tag_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] pool_count_reg, pool_count_next;
    logic [15:0] next_slot_reg, next_slot_next;
    logic [15:0] walk_slot_reg, walk_slot_next;
    logic [4:0]  ent_tag_reg, ent_tag_next;
    logic [15:0] ra_reg, ra_next;
    logic [15:0] rb_reg, rb_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] slot_reg, slot_next;
    logic [7:0]  tag_reg, tag_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] second_reg, second_next;
    logic [7:0]  rkind_reg, rkind_next;
    logic [63:0] bits_reg, bits_next;
    logic [7:0]  pay_reg, pay_next;
    logic [2:0]  err_reg, err_next;
    logic        last_reg, last_next;

    logic [63:0] acc_shift;
    logic [15:0] cnt_val;
    logic        wide;
    logic [16:0] nxt_slot;
    logic [15:0] e_first, e_second;
    logic [7:0]  e_rkind;
    logic [63:0] e_bits;

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [ccpp_pkg::STORE_W-1:0] wr_data;
    logic [AW-1:0]             rd_addr;
    logic [ccpp_pkg::STORE_W-1:0] rd_data;
    logic [15:0]               slot_m1, walk_m1, ra_m1, rb_m1;
    logic [7:0]                rd_tag;

    assign acc_shift = {acc_reg[55:0], data_byte};
    assign cnt_val   = {acc_reg[7:0], data_byte};
    assign wide      = (cur_tag_reg == ccpp_pkg::T_LONG) || (cur_tag_reg == ccpp_pkg::T_DOUBLE);
    assign nxt_slot  = {1'b0, next_slot_reg} + (wide ? 17'd2 : 17'd1);
    assign rd_tag    = {3'b000, rd_data[36:32]};
    assign slot_m1   = next_slot_reg - 16'd1;
    assign walk_m1   = walk_slot_reg - 16'd1;
    assign ra_m1     = ra_reg - 16'd1;
    assign rb_m1     = rb_reg - 16'd1;

    // Fields of a finished entry, taken from the assembled big-endian bytes.
    always_comb
    begin
        e_first  = '0;
        e_second = '0;
        e_rkind  = '0;
        e_bits   = '0;
        unique case (cur_tag_reg)
            ccpp_pkg::T_UTF8, ccpp_pkg::T_CLASS, ccpp_pkg::T_STRING, ccpp_pkg::T_MTYPE:
            begin
                e_first = acc_shift[15:0];
            end
            ccpp_pkg::T_INT, ccpp_pkg::T_FLOAT:
            begin
                e_bits = {32'd0, acc_shift[31:0]};
            end
            ccpp_pkg::T_LONG, ccpp_pkg::T_DOUBLE:
            begin
                e_bits = acc_shift;
            end
            ccpp_pkg::T_MHANDLE:
            begin
                e_rkind = acc_shift[23:16];
                e_first = acc_shift[15:0];
            end
            default:
            begin
                e_first  = acc_shift[31:16];
                e_second = acc_shift[15:0];
            end
        endcase
    end

    always_comb
    begin
        st.out_free  = !out_valid_reg || !out_stall;
        st.cnt_zero  = (cnt_val == 16'd0);
        st.cnt_over  = ({1'b0, cnt_val} > CAP_LIMIT);
        st.cnt_one   = (cnt_val == 16'd1);
        st.tag_ok    = (ccpp_pkg::field_bytes(data_byte) != 4'd0);
        st.fld_last  = (bytes_left_reg == 16'd1);
        st.utf8_more = (cur_tag_reg == ccpp_pkg::T_UTF8) && (acc_shift[15:0] != 16'd0);
        st.pay_last  = (bytes_left_reg == 16'd1);
        st.adv_end   = (nxt_slot >= {1'b0, pool_count_reg});
        st.pad_need  = wide && (({1'b0, next_slot_reg} + 17'd1) < {1'b0, pool_count_reg});
        st.walk_end  = (walk_slot_reg >= pool_count_reg);
        st.kind_bad  = (rd_tag == ccpp_pkg::T_MHANDLE)
                       && ((rd_data[15:0] < ccpp_pkg::KIND_MIN)
                           || (rd_data[15:0] > ccpp_pkg::KIND_MAX));
        st.need_a    = ccpp_pkg::needs_a({3'b000, ent_tag_reg});
        st.need_b    = ccpp_pkg::needs_b({3'b000, ent_tag_reg});
        st.a_bad_idx = (ra_reg == 16'd0) || (ra_reg >= pool_count_reg);
        st.b_bad_idx = (rb_reg == 16'd0) || (rb_reg >= pool_count_reg);
        st.a_ok      = ccpp_pkg::ref_a_ok({3'b000, ent_tag_reg}, rd_tag);
        st.b_ok      = ccpp_pkg::ref_b_ok({3'b000, ent_tag_reg}, rd_tag);
    end

    // Slot store: entry record on the last field byte, an empty record for the
    // upper half of a long or double.
    always_comb
    begin
        wr_en   = ((cmd.op == ccpp_pkg::OP_FIELD) && st.fld_last) || (cmd.op == ccpp_pkg::OP_PAD);
        wr_addr = slot_m1[AW-1:0];
        wr_data = {cur_tag_reg[4:0], e_first,
                   (cur_tag_reg == ccpp_pkg::T_MHANDLE) ? {8'd0, e_rkind} : e_second};
        if (cmd.op == ccpp_pkg::OP_PAD)
        begin
            wr_addr = next_slot_reg[AW-1:0];
            wr_data = '0;
        end
        unique case (cmd.op)
            ccpp_pkg::OP_W_ARD: rd_addr = ra_m1[AW-1:0];
            ccpp_pkg::OP_W_BRD: rd_addr = rb_m1[AW-1:0];
            default:            rd_addr = walk_m1[AW-1:0];
        endcase
    end

    ccpp_ram #(
        .WIDTH (ccpp_pkg::STORE_W),
        .DEPTH (POOL_SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        acc_next        = acc_reg;
        cur_tag_next    = cur_tag_reg;
        bytes_left_next = bytes_left_reg;
        pool_count_next = pool_count_reg;
        next_slot_next  = next_slot_reg;
        walk_slot_next  = walk_slot_reg;
        ent_tag_next    = ent_tag_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        unique case (cmd.op)
            ccpp_pkg::OP_START:
            begin
                acc_next = {56'd0, data_byte};
            end
            ccpp_pkg::OP_COUNT:
            begin
                pool_count_next = cnt_val;
                next_slot_next  = 16'd1;
                walk_slot_next  = 16'd1;
                acc_next        = '0;
            end
            ccpp_pkg::OP_TAG:
            begin
                if (st.tag_ok)
                begin
                    cur_tag_next    = data_byte;
                    bytes_left_next = {12'd0, ccpp_pkg::field_bytes(data_byte)};
                    acc_next        = '0;
                end
            end
            ccpp_pkg::OP_FIELD:
            begin
                acc_next        = acc_shift;
                bytes_left_next = st.fld_last ? acc_shift[15:0] : bytes_left_reg - 16'd1;
            end
            ccpp_pkg::OP_PAY:
            begin
                bytes_left_next = bytes_left_reg - 16'd1;
            end
            ccpp_pkg::OP_W_ENT:
            begin
                ent_tag_next = rd_data[36:32];
                ra_next      = rd_data[31:16];
                rb_next      = rd_data[15:0];
            end
            default:
            begin
            end
        endcase
        if (cmd.adv)
        begin
            next_slot_next = nxt_slot[15:0];
        end
        if (cmd.walk_inc)
        begin
            walk_slot_next = walk_slot_reg + 16'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        tag_next       = tag_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        rkind_next     = rkind_reg;
        bits_next      = bits_reg;
        pay_next       = pay_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        if (cmd.emit != ccpp_pkg::EM_NONE)
        begin
            out_valid_next = 1'b1;
            kind_next      = ccpp_pkg::RK_ERROR;
            slot_next      = '0;
            tag_next       = '0;
            first_next     = '0;
            second_next    = '0;
            rkind_next     = '0;
            bits_next      = '0;
            pay_next       = '0;
            err_next       = cmd.err;
            last_next      = 1'b1;
        end
        unique case (cmd.emit)
            ccpp_pkg::EM_ENTRY:
            begin
                kind_next   = ccpp_pkg::RK_ENTRY;
                slot_next   = next_slot_reg;
                tag_next    = cur_tag_reg;
                first_next  = e_first;
                second_next = e_second;
                rkind_next  = e_rkind;
                bits_next   = e_bits;
                err_next    = ccpp_pkg::ERR_NONE;
                last_next   = 1'b0;
            end
            ccpp_pkg::EM_PAYLOAD:
            begin
                kind_next  = ccpp_pkg::RK_PAYLOAD;
                slot_next  = next_slot_reg;
                tag_next   = ccpp_pkg::T_UTF8;
                first_next = acc_reg[15:0];
                pay_next   = data_byte;
                err_next   = ccpp_pkg::ERR_NONE;
                last_next  = 1'b0;
            end
            ccpp_pkg::EM_TAG_ERR:
            begin
                slot_next = next_slot_reg;
                tag_next  = data_byte;
            end
            ccpp_pkg::EM_WALK_ERR:
            begin
                slot_next = walk_slot_reg;
                tag_next  = {3'b000, ent_tag_reg};
            end
            ccpp_pkg::EM_VERDICT:
            begin
                kind_next = ccpp_pkg::RK_VERDICT;
                err_next  = ccpp_pkg::ERR_NONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            cur_tag_reg    <= '0;
            bytes_left_reg <= '0;
            pool_count_reg <= '0;
            next_slot_reg  <= 16'd1;
            walk_slot_reg  <= 16'd1;
            ent_tag_reg    <= '0;
            ra_reg         <= '0;
            rb_reg         <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= '0;
            slot_reg       <= '0;
            tag_reg        <= '0;
            first_reg      <= '0;
            second_reg     <= '0;
            rkind_reg      <= '0;
            bits_reg       <= '0;
            pay_reg        <= '0;
            err_reg        <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            cur_tag_reg    <= cur_tag_next;
            bytes_left_reg <= bytes_left_next;
            pool_count_reg <= pool_count_next;
            next_slot_reg  <= next_slot_next;
            walk_slot_reg  <= walk_slot_next;
            ent_tag_reg    <= ent_tag_next;
            ra_reg         <= ra_next;
            rb_reg         <= rb_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            slot_reg       <= slot_next;
            tag_reg        <= tag_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            rkind_reg      <= rkind_next;
            bits_reg       <= bits_next;
            pay_reg        <= pay_next;
            err_reg        <= err_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign slot           = slot_reg;
    assign entry_tag      = tag_reg;
    assign first_index    = first_reg;
    assign second_index   = second_reg;
    assign reference_kind = rkind_reg;
    assign constant_bits  = bits_reg;
    assign payload_byte   = pay_reg;
    assign error_code     = err_reg;
    assign last           = last_reg;

    `CCPP_ASSERT_IMPL(a_store_write_in_parse, wr_en,
        (cmd.op == ccpp_pkg::OP_FIELD) || (cmd.op == ccpp_pkg::OP_PAD),
        "slot store written outside parsing")
    `CCPP_ASSERT_IMPL(a_last_on_final, out_valid_reg,
        last_reg == ((kind_reg == ccpp_pkg::RK_VERDICT) || (kind_reg == ccpp_pkg::RK_ERROR)),
        "last flag does not match result kind")

endmodule

// ----- rtl/ccpp_ctrl.sv -----
// Controller state machine of the constant-pool parser.
`include "assert_macros.svh"

module ccpp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              start_of_pool,
    input  ccpp_pkg::status_t st,
    output ccpp_pkg::cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CNT  = 13'b0000000000010,
        S_TAG  = 13'b0000000000100,
        S_FLD  = 13'b0000000001000,
        S_PAY  = 13'b0000000010000,
        S_PAD  = 13'b0000000100000,
        S_WISS = 13'b0000001000000,
        S_WENT = 13'b0000010000000,
        S_WARD = 13'b0000100000000,
        S_WACK = 13'b0001000000000,
        S_WBRD = 13'b0010000000000,
        S_WBCK = 13'b0100000000000,
        S_VERD = 13'b1000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] verr_reg, verr_next;
    logic       in_ready;
    logic       take;
    logic       walking;

    assign in_ready = ((state_reg == S_IDLE) || (state_reg == S_CNT) || (state_reg == S_TAG)
                       || (state_reg == S_FLD) || (state_reg == S_PAY)) && st.out_free;
    assign take     = in_valid && in_ready;
    assign in_stall = !in_ready;
    assign walking  = (state_reg == S_WISS) || (state_reg == S_WENT) || (state_reg == S_WARD)
                      || (state_reg == S_WACK) || (state_reg == S_WBRD)
                      || (state_reg == S_WBCK) || (state_reg == S_VERD);

    always_comb
    begin
        state_next   = state_reg;
        verr_next    = verr_reg;
        cmd.op       = ccpp_pkg::OP_NONE;
        cmd.adv      = 1'b0;
        cmd.walk_inc = 1'b0;
        cmd.emit     = ccpp_pkg::EM_NONE;
        cmd.err      = ccpp_pkg::ERR_NONE;
        unique case (state_reg)
            S_IDLE, S_CNT, S_TAG, S_FLD, S_PAY:
            begin
                if (take && start_of_pool)
                begin
                    cmd.op     = ccpp_pkg::OP_START;
                    state_next = S_CNT;
                end
                else if (take && (state_reg == S_CNT))
                begin
                    cmd.op = ccpp_pkg::OP_COUNT;
                    if (st.cnt_zero)
                    begin
                        cmd.emit   = ccpp_pkg::EM_CNT_ERR;
                        cmd.err    = ccpp_pkg::ERR_ZERO;
                        state_next = S_IDLE;
                    end
                    else if (st.cnt_over)
                    begin
                        cmd.emit   = ccpp_pkg::EM_CNT_ERR;
                        cmd.err    = ccpp_pkg::ERR_CAP;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = st.cnt_one ? S_WISS : S_TAG;
                    end
                end
                else if (take && (state_reg == S_TAG))
                begin
                    cmd.op = ccpp_pkg::OP_TAG;
                    if (st.tag_ok)
                    begin
                        state_next = S_FLD;
                    end
                    else
                    begin
                        cmd.emit   = ccpp_pkg::EM_TAG_ERR;
                        cmd.err    = ccpp_pkg::ERR_TAG;
                        state_next = S_IDLE;
                    end
                end
                else if (take && (state_reg == S_FLD))
                begin
                    cmd.op = ccpp_pkg::OP_FIELD;
                    if (st.fld_last)
                    begin
                        cmd.emit = ccpp_pkg::EM_ENTRY;
                        if (st.utf8_more)
                        begin
                            state_next = S_PAY;
                        end
                        else if (st.pad_need)
                        begin
                            state_next = S_PAD;
                        end
                        else
                        begin
                            cmd.adv    = 1'b1;
                            state_next = st.adv_end ? S_WISS : S_TAG;
                        end
                    end
                end
                else if (take && (state_reg == S_PAY))
                begin
                    cmd.op   = ccpp_pkg::OP_PAY;
                    cmd.emit = ccpp_pkg::EM_PAYLOAD;
                    if (st.pay_last)
                    begin
                        cmd.adv    = 1'b1;
                        state_next = st.adv_end ? S_WISS : S_TAG;
                    end
                end
            end
            S_PAD:
            begin
                cmd.op     = ccpp_pkg::OP_PAD;
                cmd.adv    = 1'b1;
                state_next = st.adv_end ? S_WISS : S_TAG;
            end
            S_WISS:
            begin
                if (st.walk_end)
                begin
                    verr_next  = ccpp_pkg::ERR_NONE;
                    state_next = S_VERD;
                end
                else
                begin
                    cmd.op     = ccpp_pkg::OP_W_ISS;
                    state_next = S_WENT;
                end
            end
            S_WENT:
            begin
                cmd.op = ccpp_pkg::OP_W_ENT;
                if (st.kind_bad)
                begin
                    verr_next  = ccpp_pkg::ERR_KIND;
                    state_next = S_VERD;
                end
                else
                begin
                    state_next = S_WARD;
                end
            end
            S_WARD:
            begin
                if (!st.need_a)
                begin
                    state_next = S_WBRD;
                end
                else if (st.a_bad_idx)
                begin
                    verr_next  = ccpp_pkg::ERR_REF;
                    state_next = S_VERD;
                end
                else
                begin
                    cmd.op     = ccpp_pkg::OP_W_ARD;
                    state_next = S_WACK;
                end
            end
            S_WACK:
            begin
                if (st.a_ok)
                begin
                    state_next = S_WBRD;
                end
                else
                begin
                    verr_next  = ccpp_pkg::ERR_REF;
                    state_next = S_VERD;
                end
            end
            S_WBRD:
            begin
                if (!st.need_b)
                begin
                    cmd.walk_inc = 1'b1;
                    state_next   = S_WISS;
                end
                else if (st.b_bad_idx)
                begin
                    verr_next  = ccpp_pkg::ERR_REF;
                    state_next = S_VERD;
                end
                else
                begin
                    cmd.op     = ccpp_pkg::OP_W_BRD;
                    state_next = S_WBCK;
                end
            end
            S_WBCK:
            begin
                if (st.b_ok)
                begin
                    cmd.walk_inc = 1'b1;
                    state_next   = S_WISS;
                end
                else
                begin
                    verr_next  = ccpp_pkg::ERR_REF;
                    state_next = S_VERD;
                end
            end
            S_VERD:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = (verr_reg == ccpp_pkg::ERR_NONE) ? ccpp_pkg::EM_VERDICT
                                                                  : ccpp_pkg::EM_WALK_ERR;
                    cmd.err    = verr_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            verr_reg  <= ccpp_pkg::ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            verr_reg  <= verr_next;
        end
    end

    `CCPP_ASSERT_IMPL(a_emit_has_room, cmd.emit != ccpp_pkg::EM_NONE, st.out_free,
        "result issued while the output register is held")
    `CCPP_ASSERT_IMPL(a_no_beat_in_walk, walking, in_stall,
        "input beat accepted during the reference walk")

endmodule

// ----- rtl/class_constant_pool_parser_unit.sv -----
// Top level of the constant-pool parser: controller, datapath and slot store.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_stall   | data_byte, start_of_pool
//   out     | out_valid/out_stall | result_kind, slot, entry_tag, first_index,
//           |                    | second_index, reference_kind, constant_bits,
//           |                    | payload_byte, error_code, last
//
// Parsing takes one byte per cycle while the output register drains; a long
// or double passes through a pad state to write its empty upper slot.
// After the last entry the walk reads the slot store through its single read
// port: issue, entry, reference reads and checks per slot, then the verdict.
// Input is stalled during the pad write and the walk, and whenever a result
// waits in the output register that is not taken in the same cycle.
// Reset clears the registers but not the slot store; it needs no clearing pass.
module class_constant_pool_parser_unit #(
    parameter int unsigned POOL_SLOTS = ccpp_pkg::POOL_SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_of_pool,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [15:0] slot,
    output logic [7:0]  entry_tag,
    output logic [15:0] first_index,
    output logic [15:0] second_index,
    output logic [7:0]  reference_kind,
    output logic [63:0] constant_bits,
    output logic [7:0]  payload_byte,
    output logic [2:0]  error_code,
    output logic        last
);

    ccpp_pkg::cmd_t    cmd;
    ccpp_pkg::status_t st;

    ccpp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_of_pool (start_of_pool),
        .st            (st),
        .cmd           (cmd)
    );

    ccpp_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .slot           (slot),
        .entry_tag      (entry_tag),
        .first_index    (first_index),
        .second_index   (second_index),
        .reference_kind (reference_kind),
        .constant_bits  (constant_bits),
        .payload_byte   (payload_byte),
        .error_code     (error_code),
        .last           (last)
    );

endmodule
